// ===== hdl/encas_pkg.sv =====
`default_nettype none
package encas_pkg;

  localparam int Q_BITS = 24;
  localparam int ADDR_W = 5;
  localparam int DVD_W = 32 + Q_BITS;
  localparam int DCNT_W = 6;

  localparam logic [1:0] CMD_SAMPLE    = 2'd0;
  localparam logic [1:0] CMD_SET_ELEC  = 2'd1;
  localparam logic [1:0] CMD_SET_MECH  = 2'd2;
  localparam logic [1:0] CMD_SET_SPEED = 2'd3;

  localparam logic [2:0] REG_COUNT_RANGE   = 3'd0;
  localparam logic [2:0] REG_COUNT_OFFSET  = 3'd1;
  localparam logic [2:0] REG_POLE_PAIRS    = 3'd2;
  localparam logic [2:0] REG_SPEED_DIVIDER = 3'd3;
  localparam logic [2:0] REG_SPEED_GAIN    = 3'd4;
  localparam logic [2:0] REG_FILTER_WEIGHT = 3'd5;

  typedef enum logic [1:0] {
    MUL_ELEC,
    MUL_RAW,
    MUL_WSPD,
    MUL_WRAW
  } mul_sel_t;

  typedef struct packed {
    logic [1:0]         command;
    logic [15:0]        raw_count;
    logic signed [31:0] set_value;
  } sample_t;

  typedef struct packed {
    logic [Q_BITS-1:0]  mech_angle;
    logic [Q_BITS-1:0]  elec_angle;
    logic signed [31:0] speed_value;
    logic               speed_updated;
    logic               ready_res;
  } result_t;

  typedef struct packed {
    logic [16:0]        count_range;
    logic [15:0]        count_offset;
    logic [29:0]        pole_pair_gain;
    logic [15:0]        speed_divider;
    logic signed [31:0] speed_gain;
    logic [24:0]        filter_weight;
  } cfg_t;

  typedef struct packed {
    logic     load;
    logic     apply_set;
    logic     div_init;
    logic     div_step;
    logic     mech_store;
    logic     elec_store;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     hold_raw;
    logic     hold_acc;
    logic     speed_store;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic is_set;
    logic ready;
    logic div_last;
    logic upd;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== hdl/encas_regs.sv =====
`default_nettype none
module encas_regs
  import encas_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output cfg_t                   cfg
);

  logic [2:0] idx;
  assign idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.count_range    <= 17'd4096;
      cfg.count_offset   <= 16'd0;
      cfg.pole_pair_gain <= 30'd16777216;
      cfg.speed_divider  <= 16'd1;
      cfg.speed_gain     <= 32'sd16777216;
      cfg.filter_weight  <= 25'd0;
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_COUNT_RANGE:   cfg.count_range    <= pwdata[16:0];
        REG_COUNT_OFFSET:  cfg.count_offset   <= pwdata[15:0];
        REG_POLE_PAIRS:    cfg.pole_pair_gain <= pwdata[29:0];
        REG_SPEED_DIVIDER: cfg.speed_divider  <= pwdata[15:0];
        REG_SPEED_GAIN:    cfg.speed_gain     <= pwdata;
        REG_FILTER_WEIGHT: cfg.filter_weight  <= pwdata[24:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_COUNT_RANGE:   prdata = {15'd0, cfg.count_range};
      REG_COUNT_OFFSET:  prdata = {16'd0, cfg.count_offset};
      REG_POLE_PAIRS:    prdata = {2'd0, cfg.pole_pair_gain};
      REG_SPEED_DIVIDER: prdata = {16'd0, cfg.speed_divider};
      REG_SPEED_GAIN:    prdata = cfg.speed_gain;
      REG_FILTER_WEIGHT: prdata = {7'd0, cfg.filter_weight};
      default:           prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/encas_dp.sv =====
`default_nettype none
module encas_dp
  import encas_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire sample_t sample,
  input  wire cfg_t    cfg,
  input  wire dp_cmd_t cmd,
  output dp_status_t   st,
  output result_t      result
);

  sample_t            item;
  logic [Q_BITS-1:0]  mech, elec, prev;
  logic signed [31:0] spd;
  logic [15:0]        sc;
  logic               upd;
  logic [16:0]        rem;
  logic [DVD_W-1:0]   dvd;
  logic [Q_BITS-1:0]  quot;
  logic [DCNT_W-1:0]  div_cnt;
  logic signed [31:0] p, acc, raw_spd;

  logic [31:0]        wrapped;
  logic [17:0]        trial;
  logic               ge;
  logic [16:0]        rem_next;
  logic [15:0]        sc_inc, div_eff;
  logic               upd_now;
  logic [Q_BITS-1:0]  delta;
  logic signed [31:0] ma, mb;
  logic signed [63:0] prod;

  // Offset removal wraps at 32 bits, as the long division expects.
  assign wrapped = {16'd0, sample.raw_count} + {15'd0, cfg.count_range}
                 - {16'd0, cfg.count_offset};
  assign trial    = {rem, dvd[DVD_W-1]};
  assign ge       = trial >= {1'b0, cfg.count_range};
  assign rem_next = ge ? 17'(trial - {1'b0, cfg.count_range}) : trial[16:0];

  assign sc_inc  = sc + 16'd1;
  assign div_eff = (cfg.speed_divider == 16'd0) ? 16'd1 : cfg.speed_divider;
  assign upd_now = sc_inc >= div_eff;
  assign delta   = mech - prev;

  always_comb begin
    case (cmd.mul_sel)
      MUL_ELEC: begin
        ma = {{(32-Q_BITS){1'b0}}, quot};
        mb = {2'd0, cfg.pole_pair_gain};
      end
      MUL_RAW: begin
        ma = {{(32-Q_BITS){delta[Q_BITS-1]}}, delta};
        mb = cfg.speed_gain;
      end
      MUL_WSPD: begin
        ma = {7'd0, cfg.filter_weight};
        mb = spd;
      end
      MUL_WRAW: begin
        ma = (32'd1 << Q_BITS) - {7'd0, cfg.filter_weight};
        mb = raw_spd;
      end
      default: begin
        ma = 32'sd0;
        mb = 32'sd0;
      end
    endcase
  end

  assign prod = ma * mb;

  always_ff @(posedge clk) begin
    if (rst) begin
      mech    <= '0;
      elec    <= '0;
      prev    <= '0;
      spd     <= '0;
      sc      <= '0;
      upd     <= 1'b0;
      div_cnt <= '0;
    end else begin
      if (cmd.load) begin
        item <= sample;
        upd  <= 1'b0;
        dvd  <= {wrapped, {Q_BITS{1'b0}}};
      end
      if (cmd.apply_set) begin
        case (item.command)
          CMD_SET_ELEC:  elec <= item.set_value[Q_BITS-1:0];
          CMD_SET_MECH:  mech <= item.set_value[Q_BITS-1:0];
          CMD_SET_SPEED: spd  <= item.set_value;
          default: ;
        endcase
      end
      if (cmd.div_init) begin
        rem     <= '0;
        div_cnt <= '0;
      end
      if (cmd.div_step) begin
        rem     <= rem_next;
        dvd     <= dvd << 1;
        quot    <= {quot[Q_BITS-2:0], ge};
        div_cnt <= div_cnt + 1'b1;
      end
      if (cmd.mech_store) begin
        mech <= quot;
        sc   <= upd_now ? 16'd0 : sc_inc;
        upd  <= upd_now;
      end
      if (cmd.mul_en)     p <= prod[32+Q_BITS-1:Q_BITS];
      if (cmd.elec_store) elec <= p[Q_BITS-1:0];
      if (cmd.hold_raw)   raw_spd <= p;
      if (cmd.hold_acc)   acc <= p;
      if (cmd.speed_store) begin
        spd  <= acc + p;
        prev <= mech;
      end
      if (cmd.out_load) begin
        result.mech_angle    <= mech;
        result.elec_angle    <= elec;
        result.speed_value   <= spd;
        result.speed_updated <= upd;
        result.ready_res     <= st.ready;
      end
    end
  end

  assign st.is_set   = item.command != CMD_SAMPLE;
  assign st.ready    = cfg.count_range != 17'd0;
  assign st.div_last = div_cnt == DCNT_W'(DVD_W - 1);
  assign st.upd      = upd;

endmodule
`default_nettype wire

// ===== hdl/encas_ctrl.sv =====
`default_nettype none
module encas_ctrl
  import encas_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       sample_valid,
  output logic            sample_ready,
  output logic            result_valid,
  input  wire logic       result_ready,
  input  wire dp_status_t st,
  output dp_cmd_t         cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_DIV, S_MECH, S_ELEC, S_RAW, S_WSPD, S_WRAW, S_SUM, S_FINISH
  } state_t;

  state_t state;

  assign sample_ready = state == S_IDLE;

  always_comb begin
    cmd = '0;
    cmd.mul_sel = MUL_ELEC;
    case (state)
      S_IDLE:   cmd.load = sample_valid;
      S_DECIDE: begin
        cmd.apply_set = st.is_set;
        cmd.div_init  = !st.is_set && st.ready;
      end
      S_DIV:    cmd.div_step = 1'b1;
      S_MECH: begin
        cmd.mech_store = 1'b1;
        cmd.mul_en     = 1'b1;
        cmd.mul_sel    = MUL_ELEC;
      end
      S_ELEC:   cmd.elec_store = 1'b1;
      S_RAW: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_RAW;
      end
      S_WSPD: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MUL_WSPD;
        cmd.hold_raw = 1'b1;
      end
      S_WRAW: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MUL_WRAW;
        cmd.hold_acc = 1'b1;
      end
      S_SUM:    cmd.speed_store = 1'b1;
      S_FINISH: cmd.out_load = !result_valid || result_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE:   if (sample_valid) state <= S_DECIDE;
        S_DECIDE: state <= (!st.is_set && st.ready) ? S_DIV : S_FINISH;
        S_DIV:    if (st.div_last) state <= S_MECH;
        S_MECH:   state <= S_ELEC;
        S_ELEC:   state <= st.upd ? S_RAW : S_FINISH;
        S_RAW:    state <= S_WSPD;
        S_WSPD:   state <= S_WRAW;
        S_WRAW:   state <= S_SUM;
        S_SUM:    state <= S_FINISH;
        S_FINISH: if (cmd.out_load) state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hdl/encoder_angle_speed_estimator.sv =====
`default_nettype none
// Encoder angle and speed estimator. Each sample transaction carries a raw
// encoder count, which is reduced modulo the count range and turned into a Q24
// mechanical angle by one restoring long division of 56 steps, one quotient bit
// per clock; the electrical angle and, every speed_divider-th sample, the
// filtered speed come from one shared 32 by 32 multiplier used over several
// clocks. One item is in work at a time, while the previous result may still
// wait in the output register. Set commands act even with a zero count range,
// which otherwise gives results with ready_res low. Registers sit on the APB
// port at byte addresses 4*i and read back the bits that they hold, with zero
// in the unused upper bits.
module encoder_angle_speed_estimator
  import encas_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              sample_valid,
  output logic                   sample_ready,
  input  wire sample_t           sample,
  output logic                   result_valid,
  input  wire logic              result_ready,
  output result_t                result,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t st;

  assign pready = 1'b1;

  // Configuration registers behind the APB port.
  encas_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .cfg
  );

  // Sequencer that steps the divider and multiplier.
  encas_ctrl u_ctrl (
    .clk, .rst, .sample_valid, .sample_ready, .result_valid, .result_ready,
    .st, .cmd
  );

  // Angle, speed and counter state with the shared arithmetic.
  encas_dp u_dp (
    .clk, .rst, .sample, .cfg, .cmd, .st, .result
  );

`ifndef SYNTHESIS
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (sample_valid && sample_ready) |=> !sample_ready)
    else $error("second transaction accepted while one is in work");

  a_update_needs_ready: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.speed_updated) |-> result.ready_res)
    else $error("speed updated without a valid count range");

  a_load_only_finish: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !cmd.out_load)
    else $error("result loaded while taking a new transaction");
`endif

endmodule
`default_nettype wire
